// File: rtl/lgrs_pkg.sv
// Shared types, constants and the B3/S23 rule for the Life row stepper.
// Depends on nothing; every other file in rtl imports it.
`default_nettype none

package lgrs_pkg;

   localparam int ROW_W      = 64;
   localparam int COL_W      = 7;
   localparam int CNT_W      = 12;
   localparam int RSP_DATA_W = 80;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLUMNS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS    = 1'd1;

   localparam logic [COL_W-1:0] GRID_COLUMNS_RESET = 7'd38;
   localparam logic [CNT_W-1:0] GRID_ROWS_RESET    = 12'd18;

   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   localparam int OQ_DEPTH = 4;
   localparam int OQ_PTR_W = 2;
   localparam int OQ_CNT_W = 3;

   typedef struct packed {
      logic above;
      logic middle;
      logic cur;
   } nbr_bits_type;

   typedef struct packed {
      logic             last_row;
      logic [CNT_W-1:0] row_index;
      logic [ROW_W-1:0] next_row_cells;
   } rsp_item_type;

   function automatic logic life_rule(input logic alive, input logic [3:0] count);
      life_rule = (count == BIRTH_COUNT) || (alive && (count == SURVIVE_COUNT));
   endfunction

endpackage

`default_nettype wire

// File: rtl/life_generation_row_stepper.sv
// Top level of the Life (B3/S23) row stepper: configuration registers, row
// counter, the chain of column cells and the result queue.
// Depends on lgrs_pkg, lgrs_cell and lgrs_out_fifo.
//
//   channel   direction  handshake               payload
//   req_      in         req_tvalid/req_tready   tdata[63:0] row_cells
//   rsp_      out        rsp_tvalid/rsp_tready   tdata[63:0] next_row_cells,
//                                                tdata[75:64] row_index,
//                                                tlast last_row
//   csr_      in         csr_valid/csr_ready     csr_index, csr_data
//
// One row per cycle while the result queue has room: every column cell updates
// in parallel when a row is taken. A row's results are registered into the queue
// (none for the first row of a multi-row generation, two for its last row); the
// four-entry queue takes a row while it holds at most two, so rsp_tready low
// stalls req_. Synchronous active-high reset clears the held rows, the row
// counter and the queue, and loads the register defaults (38 columns, 18 rows).
`default_nettype none

module life_generation_row_stepper
   import lgrs_pkg::*;
#(
   parameter int MAX_COLUMNS = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // row_cells [63:0]
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [ROW_W-1:0]      req_tdata,
   // next_row_cells [63:0], row_index [75:64], zero [79:76]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   logic [COL_W-1:0] grid_columns_ff, grid_columns_in;
   logic [CNT_W-1:0] grid_rows_ff, grid_rows_in;
   logic [CNT_W-1:0] row_counter_ff, row_counter_in;
   logic [CNT_W-1:0] rows_eff;
   logic             accept;
   logic             push_a;
   logic             push_b;
   logic             space_ok;
   logic [ROW_W-1:0] next_mid_w;
   logic [ROW_W-1:0] next_cur_w;
   rsp_item_type     item_a;
   rsp_item_type     item_b;
   rsp_item_type     first_item;
   rsp_item_type     out_item;
   nbr_bits_type     own_w [MAX_COLUMNS];

   assign csr_ready  = 1'b1;
   assign req_tready = space_ok;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      grid_columns_in = grid_columns_ff;
      grid_rows_in    = grid_rows_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GRID_COLUMNS: grid_columns_in = csr_data[COL_W-1:0];
            CSR_GRID_ROWS:    grid_rows_in    = csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign rows_eff = (grid_rows_ff == '0) ? CNT_W'(1) : grid_rows_ff;
   assign push_a   = accept && (row_counter_ff != '0);
   assign push_b   = accept && (row_counter_ff >= rows_eff - CNT_W'(1));

   always_comb begin
      row_counter_in = row_counter_ff;
      if (accept) begin
         row_counter_in = push_b ? '0 : row_counter_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_columns_ff <= GRID_COLUMNS_RESET;
         grid_rows_ff    <= GRID_ROWS_RESET;
         row_counter_ff  <= '0;
      end else begin
         grid_columns_ff <= grid_columns_in;
         grid_rows_ff    <= grid_rows_in;
         row_counter_ff  <= row_counter_in;
      end
   end

   for (genvar c = 0; c < MAX_COLUMNS; c++) begin : g_cell
      nbr_bits_type left_w;
      nbr_bits_type right_w;

      if (c == 0) begin : g_left_edge
         assign left_w = '0;
      end else begin : g_left
         assign left_w = own_w[c-1];
      end

      if (c == MAX_COLUMNS - 1) begin : g_right_edge
         assign right_w = '0;
      end else begin : g_right
         assign right_w = own_w[c+1];
      end

      lgrs_cell #(
         .COL (c)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .accept       (accept),
         .clear        (push_b),
         .grid_columns (grid_columns_ff),
         .cur_bit      (req_tdata[c]),
         .left         (left_w),
         .right        (right_w),
         .own          (own_w[c]),
         .next_mid     (next_mid_w[c]),
         .next_cur     (next_cur_w[c])
      );
   end

   for (genvar c = MAX_COLUMNS; c < ROW_W; c++) begin : g_dead
      assign next_mid_w[c] = 1'b0;
      assign next_cur_w[c] = 1'b0;
   end

   assign item_a.next_row_cells = next_mid_w;
   assign item_a.row_index      = row_counter_ff - CNT_W'(1);
   assign item_a.last_row       = 1'b0;

   assign item_b.next_row_cells = next_cur_w;
   assign item_b.row_index      = row_counter_ff;
   assign item_b.last_row       = 1'b1;

   assign first_item = push_a ? item_a : item_b;

   lgrs_out_fifo u_out_fifo (
      .clock       (clock),
      .reset       (reset),
      .push_first  (push_a | push_b),
      .push_second (push_a & push_b),
      .first_item  (first_item),
      .second_item (item_b),
      .space_ok    (space_ok),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_item    (out_item)
   );

   assign rsp_tdata = {(RSP_DATA_W - ROW_W - CNT_W)'(0), out_item.row_index,
                       out_item.next_row_cells};
   assign rsp_tlast = out_item.last_row;

endmodule

`default_nettype wire

// File: rtl/lgrs_cell.sv
// One column cell: holds the column's bits of the two previous rows and
// exchanges them with its left and right neighbors. Uses lgrs_pkg.
`default_nettype none

module lgrs_cell
   import lgrs_pkg::*;
#(
   parameter int COL = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic             clear,
   input  wire logic [COL_W-1:0] grid_columns,
   input  wire logic             cur_bit,
   input  wire nbr_bits_type     left,
   input  wire nbr_bits_type     right,
   output nbr_bits_type          own,
   output logic                  next_mid,
   output logic                  next_cur
);

   logic       in_use;
   logic       above_ff, above_in;
   logic       middle_ff, middle_in;
   logic [3:0] count_mid;
   logic [3:0] count_cur;

   assign in_use = grid_columns > COL_W'(COL);

   assign own.above  = above_ff;
   assign own.middle = middle_ff;
   assign own.cur    = cur_bit & in_use;

   assign count_mid = 4'(left.above) + 4'(left.middle) + 4'(left.cur)
                    + 4'(above_ff) + 4'(own.cur)
                    + 4'(right.above) + 4'(right.middle) + 4'(right.cur);

   assign count_cur = 4'(left.middle) + 4'(left.cur) + 4'(middle_ff)
                    + 4'(right.middle) + 4'(right.cur);

   assign next_mid = in_use & life_rule(middle_ff, count_mid);
   assign next_cur = in_use & life_rule(own.cur, count_cur);

   always_comb begin
      above_in  = above_ff;
      middle_in = middle_ff;
      if (accept) begin
         if (clear) begin
            above_in  = 1'b0;
            middle_in = 1'b0;
         end else begin
            above_in  = middle_ff;
            middle_in = own.cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff  <= 1'b0;
         middle_ff <= 1'b0;
      end else begin
         above_ff  <= above_in;
         middle_ff <= middle_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/lgrs_out_fifo.sv
// Result queue of the Life row stepper: takes one or two results per cycle
// and presents them in order on the result stream. Uses lgrs_pkg.
`default_nettype none

module lgrs_out_fifo
   import lgrs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push_first,
   input  wire logic         push_second,
   input  wire rsp_item_type first_item,
   input  wire rsp_item_type second_item,
   output logic              space_ok,
   output logic              out_valid,
   input  wire logic         out_ready,
   output rsp_item_type      out_item
);

   rsp_item_type                entries_ff [OQ_DEPTH];
   logic         [OQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic         [OQ_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic         [OQ_CNT_W-1:0] count_ff, count_in;
   logic         [OQ_PTR_W-1:0] wr_next;
   logic                        pop;

   assign out_valid = count_ff != '0;
   assign out_item  = entries_ff[rd_ptr_ff];
   assign pop       = out_valid & out_ready;
   assign space_ok  = count_ff <= OQ_CNT_W'(OQ_DEPTH - 2);
   assign wr_next   = wr_ptr_ff + OQ_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + OQ_PTR_W'(push_first) + OQ_PTR_W'(push_second);
      rd_ptr_in = rd_ptr_ff + OQ_PTR_W'(pop);
      count_in  = count_ff + OQ_CNT_W'(push_first) + OQ_CNT_W'(push_second)
                - OQ_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_first) begin
         entries_ff[wr_ptr_ff] <= first_item;
      end
      if (push_second) begin
         entries_ff[wr_next] <= second_item;
      end
   end

endmodule

`default_nettype wire

// File: sim/tb_life_generation_row_stepper.sv
// Self-checking testbench for life_generation_row_stepper: streams grid rows and checks
// every next-generation row against a B3/S23 row predictor kept inside the bench.
// Depends on lgrs_pkg and the RTL of life_generation_row_stepper.
`timescale 1ns / 100ps

module tb_life_generation_row_stepper;
   import lgrs_pkg::*;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned RANDOM_ROWS   = 1950;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [ROW_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   life_generation_row_stepper i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // row_cells [63:0]
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),    // next_row_cells [63:0], row_index [75:64], zero [79:76]
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [COL_W-1:0] cfg_columns = 7'd38;
   logic [CNT_W-1:0] cfg_rows    = 12'd18;
   logic [ROW_W-1:0] held_above  = '0;
   logic [ROW_W-1:0] held_middle = '0;
   logic [CNT_W-1:0] gen_row_pos = '0;

   rsp_item_type next_rows_q[$];
   rsp_item_type due_row;

   bit          pace_on = 1'b1;
   int unsigned ready_hold = 0;
   int unsigned cycle_count = 0;
   int unsigned rows_sent = 0;
   int unsigned rows_checked = 0;
   int unsigned csr_writes = 0;
   int unsigned grid_settings = 0;
   int unsigned mismatches = 0;

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ROW_W-1:0] columns_mask(input logic [COL_W-1:0] cols);
      if (cols >= 64) return '1;
      return (64'd1 << cols) - 64'd1;
   endfunction

   function automatic logic [ROW_W-1:0] life_next(input logic [ROW_W-1:0] up, mid, down,
                                                  input logic [ROW_W-1:0] mask);
      logic [ROW_W-1:0] born;
      int               n;
      born = '0;
      for (int c = 0; c < ROW_W; c++) begin
         n = 0;
         for (int k = c - 1; k <= c + 1; k++) begin
            if (k >= 0 && k < ROW_W) begin
               n += int'(up[k]) + int'(down[k]);
               if (k != c) n += int'(mid[k]);
            end
         end
         born[c] = (n == 3) || (mid[c] && n == 2);
      end
      return born & mask;
   endfunction

   function automatic void predict_next_rows(input logic [ROW_W-1:0] cells);
      logic [ROW_W-1:0] mask;
      logic [ROW_W-1:0] cur;
      logic [CNT_W-1:0] rows_eff;
      rsp_item_type     item;
      mask     = columns_mask(cfg_columns);
      cur      = cells & mask;
      rows_eff = (cfg_rows == 0) ? 12'd1 : cfg_rows;
      if (gen_row_pos == 0) begin
         if (rows_eff == 1) begin
            item.next_row_cells = life_next('0, cur, '0, mask);
            item.row_index      = '0;
            item.last_row       = 1'b1;
            next_rows_q.push_back(item);
            held_above  = '0;
            held_middle = '0;
         end else begin
            held_above  = '0;
            held_middle = cur;
            gen_row_pos = 12'd1;
         end
         return;
      end
      item.next_row_cells = life_next(held_above, held_middle, cur, mask);
      item.row_index      = gen_row_pos - 12'd1;
      item.last_row       = 1'b0;
      next_rows_q.push_back(item);
      if (gen_row_pos >= rows_eff - 12'd1) begin
         item.next_row_cells = life_next(held_middle, cur, '0, mask);
         item.row_index      = gen_row_pos;
         item.last_row       = 1'b1;
         next_rows_q.push_back(item);
         held_above  = '0;
         held_middle = '0;
         gen_row_pos = '0;
      end else begin
         held_above  = held_middle;
         held_middle = cur;
         gen_row_pos = gen_row_pos + 12'd1;
      end
   endfunction

   function automatic logic [ROW_W-1:0] random_cells();
      case ($urandom_range(0, 4))
         0: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         1: return {$urandom, $urandom} | {$urandom, $urandom};
         2: return 64'd1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // rsp_ stall pattern
   always @(posedge clock) begin
      if (reset || !pace_on) begin
         rsp_tready <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 2) != 0);
         ready_hold <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (next_rows_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transaction: row %0d cells %h last %b",
                        rsp_tdata[75:64], rsp_tdata[63:0], rsp_tlast);
         end else begin
            due_row = next_rows_q.pop_front();
            rows_checked++;
            if (rsp_tdata[63:0] !== due_row.next_row_cells ||
                rsp_tdata[75:64] !== due_row.row_index ||
                rsp_tlast !== due_row.last_row || rsp_tdata[79:76] !== 4'd0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected row %0d cells %h last %b, got row %0d cells %h last %b pad %h",
                           due_row.row_index, due_row.next_row_cells, due_row.last_row,
                           rsp_tdata[75:64], rsp_tdata[63:0], rsp_tlast, rsp_tdata[79:76]);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  next_rows_q.size());
         $display("life_generation_row_stepper verification failed");
         $finish;
      end
   end

   task automatic send_row(input logic [ROW_W-1:0] cells);
      int unsigned gap;
      gap = pace_on ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= cells;
      do @(posedge clock); while (!req_tready);
      predict_next_rows(cells);
      rows_sent++;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (next_rows_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      wait_for_results();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_GRID_COLUMNS) cfg_columns = value[COL_W-1:0];
      else cfg_rows = value;
      csr_writes++;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] col_word,
                            input logic [CSR_DATA_W-1:0] rows_word);
      write_csr(CSR_GRID_COLUMNS, col_word);
      write_csr(CSR_GRID_ROWS, rows_word);
      grid_settings++;
   endtask

   // default 38 x 18 grid, then shrink the generation after four rows
   task automatic test_reset_defaults();
      send_row('1);
      send_row(64'hAAAA_AAAA_AAAA_AAAA);
      send_row(64'h5555_5555_5555_5555);
      send_row(64'hFFFF_FFC0_0000_0001);
      write_csr(CSR_GRID_ROWS, 12'd2);
      send_row('1);
   endtask

   task automatic test_zero_columns();
      configure(12'h080, 12'd2);
      send_row('1);
      send_row('1);
   endtask

   task automatic test_column_saturation();
      configure(12'hFFF, 12'd3);
      send_row('1);
      send_row(64'h8000_0000_0000_0001);
      send_row(64'hC000_0000_0000_0003);
   endtask

   task automatic test_zero_rows();
      configure(12'd64, 12'd0);
      send_row('1);
      send_row(64'h8000_0000_0000_0001);
   endtask

   task automatic test_single_row();
      configure(12'd1, 12'd1);
      send_row('1);
   endtask

   task automatic test_blinker();
      configure(12'd5, 12'd5);
      send_row(64'd0);
      send_row(64'b00100);
      send_row(64'b00100);
      send_row(64'b00100);
      send_row(64'd0);
   endtask

   // tallest grid, cut short by dropping to one row
   task automatic test_tall_grid();
      configure(12'd64, 12'd4095);
      repeat (40) send_row(random_cells());
      write_csr(CSR_GRID_ROWS, 12'd1);
      send_row(random_cells());
   endtask

   task automatic test_random_generations();
      int unsigned      target;
      int unsigned      gens;
      int unsigned      rows_eff;
      logic [COL_W-1:0] cols;
      logic [CNT_W-1:0] rows;
      target = rows_sent + RANDOM_ROWS;
      while (rows_sent < target) begin
         case ($urandom_range(0, 9))
            0: cols = 7'd0;
            1: cols = 7'($urandom_range(65, 127));
            2: cols = 7'd64;
            3: cols = 7'd1;
            default: cols = 7'($urandom_range(2, 64));
         endcase
         case ($urandom_range(0, 19))
            0: rows = 12'd0;
            1: rows = 12'd1;
            2, 3: rows = 12'($urandom_range(20, 120));
            default: rows = 12'($urandom_range(2, 12));
         endcase
         configure({5'($urandom_range(0, 31)), cols}, rows);
         pace_on  = ($urandom_range(0, 3) != 0);
         rows_eff = (rows == 0) ? 1 : rows;
         gens     = (rows_eff > 20) ? 1 : $urandom_range(1, 3);
         repeat (gens * rows_eff) begin
            send_row(random_cells());
            if ($urandom_range(0, 63) == 0) wait_for_results();
         end
         // sometimes send up to one more generation of rows, often a partial one for the next setting to cut off
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, rows_eff)) send_row(random_cells());
      end
      pace_on = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_zero_columns();
      test_column_saturation();
      test_zero_rows();
      test_single_row();
      test_blinker();
      test_tall_grid();
      test_random_generations();
      wait_for_results();
      if (next_rows_q.size() != 0) begin
         mismatches += next_rows_q.size();
         $display("%0d expected results never arrived", next_rows_q.size());
      end
      $display("stepped %0d rows into %0d checked results over %0d grid settings (%0d csr writes)",
               rows_sent, rows_checked, grid_settings, csr_writes);
      $display("widths 0 to 127 and row counts 0 to 4095, mid-generation cuts, stalls on both sides");
      if (mismatches == 0)
         $display("life_generation_row_stepper verification clean");
      else
         $display("life_generation_row_stepper verification failed");
      $finish;
   end

endmodule

// File: life_generation_row_stepper.f
rtl/lgrs_pkg.sv
rtl/lgrs_cell.sv
rtl/lgrs_out_fifo.sv
rtl/life_generation_row_stepper.sv
sim/tb_life_generation_row_stepper.sv
